@@ rtl/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg
// Shared field widths and operation and status codes of the chained hash set.
// ----------------------------------------------------------------------------
`default_nettype none
package chs_pkg;
	localparam int KeyWidth    = 32;
	localparam int FuncWidth   = 2;
	localparam int StatusWidth = 3;
	localparam int CountWidth  = 9;

	typedef logic [FuncWidth-1:0]   func_t;
	typedef logic [KeyWidth-1:0]    key_t;
	typedef logic [StatusWidth-1:0] status_t;
	typedef logic [CountWidth-1:0]  count_t;

	localparam func_t FUNC_ADD    = 2'd0;
	localparam func_t FUNC_QUERY  = 2'd1;
	localparam func_t FUNC_REMOVE = 2'd2;
	// The spare code behaves as a query.
	localparam func_t FUNC_SPARE  = 2'd3;

	localparam status_t STAT_ADDED       = 3'd0;
	localparam status_t STAT_PRESENT     = 3'd1;
	localparam status_t STAT_REMOVED     = 3'd2;
	localparam status_t STAT_NOT_PRESENT = 3'd3;
	localparam status_t STAT_POOL_FULL   = 3'd4;
endpackage
`default_nettype wire

@@ rtl/chs_if.sv @@
// ----------------------------------------------------------------------------
// chs_req_if / chs_rsp_if
// Valid/ready channels for requests and results of the chained hash set.
// ----------------------------------------------------------------------------
`default_nettype none
interface chs_req_if;
	logic           valid;
	logic           ready;
	chs_pkg::func_t func;
	chs_pkg::key_t  key;
	modport source (output valid, func, key, input ready);
	modport sink   (input valid, func, key, output ready);
endinterface

interface chs_rsp_if;
	logic             valid;
	logic             ready;
	logic             found;
	chs_pkg::status_t status;
	chs_pkg::count_t  member_count;
	modport source (output valid, found, status, member_count, input ready);
	modport sink   (input valid, found, status, member_count, output ready);
endinterface
`default_nettype wire

@@ rtl/chs_bucket_unit.sv @@
// ----------------------------------------------------------------------------
// chs_bucket_unit
// Bucket index of a key: its magnitude modulo the bucket count, by a mask when
// the bucket count is a power of two, else by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_bucket_unit #(
	parameter int NUM_BUCKETS = 256,
	parameter int BW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire chs_pkg::key_t   key,
	output logic                 done,
	output logic [BW-1:0]        bucket
);
	import chs_pkg::*;

	localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam key_t MASK    = KeyWidth'(NUM_BUCKETS - 1);
	localparam key_t DIVISOR = KeyWidth'(NUM_BUCKETS);
	// Floor of 2^32 over the bucket count. For three or more buckets the
	// quotient estimate taken from it is exact or one short.
	localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(NUM_BUCKETS);
	localparam key_t RECIP = KeyWidth'(RECIP_FULL);

	localparam logic [1:0] PH_RECIP = 2'd0;
	localparam logic [1:0] PH_BACK  = 2'd1;
	localparam logic [1:0] PH_FIX   = 2'd2;

	logic                    busy_q;
	logic                    done_q;
	logic [1:0]              phase_q;
	key_t                    mag_q;
	key_t                    quot_q;
	key_t                    rem_q;
	key_t                    mag;
	key_t                    mul_a, mul_b;
	logic [2*KeyWidth-1:0]   prod;

	assign mag = key[KeyWidth-1] ? (KeyWidth'(0) - key) : key;

	// One multiplier serves both the quotient estimate and the back product.
	assign mul_a = (phase_q == PH_RECIP) ? mag_q : quot_q;
	assign mul_b = (phase_q == PH_RECIP) ? RECIP : DIVISOR;
	assign prod  = (2*KeyWidth)'(mul_a) * (2*KeyWidth)'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= PH_RECIP;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (IS_POW2) begin
					done_q <= 1'b1;
				end else begin
					busy_q  <= 1'b1;
					phase_q <= PH_RECIP;
				end
			end else if (busy_q) begin
				unique case (phase_q)
					PH_RECIP: phase_q <= PH_BACK;
					PH_BACK:  phase_q <= PH_FIX;
					PH_FIX: begin
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						phase_q <= PH_RECIP;
					end
					default: phase_q <= PH_RECIP;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			if (IS_POW2) begin
				rem_q <= mag & MASK;
			end
		end else if (busy_q) begin
			unique case (phase_q)
				PH_RECIP: quot_q <= prod[2*KeyWidth-1:KeyWidth];
				PH_BACK:  rem_q  <= mag_q - prod[KeyWidth-1:0];
				PH_FIX: begin
					if (rem_q >= DIVISOR) begin
						rem_q <= rem_q - DIVISOR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = rem_q[BW-1:0];
endmodule
`default_nettype wire

@@ rtl/chained_hash_set_core.sv @@
// ----------------------------------------------------------------------------
// chained_hash_set_core
// Set of signed 32-bit keys in a hash table with separate chaining.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bucket and link memories and takes no
// request meanwhile. Each request then runs alone under a small sequencer:
// the request transfer, the bucket index (by a mask for a power-of-two
// bucket count, else by reciprocal multiplication), the head read, a read of
// each chain node visited through the shared node read address plus a final
// check at the end of the chain when the key is absent, a decision, the
// writes for an add or a remove that changes the set, and the result, offered
// until it is taken. The request port is ready only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_set_core #(
	parameter int NUM_BUCKETS = 256,
	parameter int POOL_SIZE   = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chs_req_if.sink   req,
	chs_rsp_if.source rsp
);
	import chs_pkg::*;

	localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int IW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int LW   = $clog2(POOL_SIZE + 1);
	localparam int MAXD = (NUM_BUCKETS > POOL_SIZE) ? NUM_BUCKETS : POOL_SIZE;
	localparam int SW   = $clog2(MAXD + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SIZE);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_HASH     = 4'd2;
	localparam logic [3:0] S_HEAD     = 4'd3;
	localparam logic [3:0] S_LOAD     = 4'd4;
	localparam logic [3:0] S_WALK     = 4'd5;
	localparam logic [3:0] S_CMP      = 4'd6;
	localparam logic [3:0] S_DECIDE   = 4'd7;
	localparam logic [3:0] S_ALLOC    = 4'd8;
	localparam logic [3:0] S_ADD_LINK = 4'd9;
	localparam logic [3:0] S_REM_LINK = 4'd10;
	localparam logic [3:0] S_REM_FREE = 4'd11;
	localparam logic [3:0] S_RESP     = 4'd12;

	logic [3:0]    state_q;
	logic [SW-1:0] sweep_q;
	func_t         func_q;
	key_t          key_q;
	logic [BW-1:0] bucket_q;
	logic [LW-1:0] cur_q, prev_q, new_q, free_q, count_q, steps_q;
	logic          found_q;
	status_t       status_q;

	logic [LW-1:0] heads_mem [NUM_BUCKETS];
	logic [LW-1:0] links_mem [POOL_SIZE];
	key_t          keys_mem  [POOL_SIZE];
	logic [LW-1:0] head_rd_q, link_rd_q;
	key_t          key_rd_q;

	logic          hash_start, hash_done;
	logic [BW-1:0] hash_bucket;

	logic          heads_we, links_we, keys_we;
	logic [BW-1:0] heads_wa;
	logic [LW-1:0] heads_wd, links_wd;
	logic [IW-1:0] links_wa, rd_addr;

	chs_bucket_unit #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = (state_q == S_RESP);
	assign rsp.found         = found_q;
	assign rsp.status        = status_q;
	assign rsp.member_count  = CountWidth'(count_q);

	// The hash unit starts in the cycle after the request transfer.
	logic hash_go_q;
	assign hash_start = hash_go_q;

	always_comb begin
		heads_we = 1'b0;
		heads_wa = bucket_q;
		heads_wd = new_q;
		links_we = 1'b0;
		links_wa = prev_q[IW-1:0];
		links_wd = new_q;
		keys_we  = 1'b0;
		rd_addr  = cur_q[IW-1:0];
		unique case (state_q)
			S_INIT: begin
				heads_we = (SW'(sweep_q) < SW'(NUM_BUCKETS));
				heads_wa = sweep_q[BW-1:0];
				heads_wd = NULL_LINK;
				links_we = (SW'(sweep_q) < SW'(POOL_SIZE));
				links_wa = sweep_q[IW-1:0];
				links_wd = LW'(sweep_q) + LW'(1);
			end
			S_DECIDE: begin
				if (func_q == FUNC_ADD) begin
					rd_addr = free_q[IW-1:0];
				end
			end
			S_ALLOC: begin
				keys_we  = 1'b1;
				links_we = 1'b1;
				links_wa = free_q[IW-1:0];
				links_wd = NULL_LINK;
			end
			S_ADD_LINK: begin
				if (prev_q == NULL_LINK) begin
					heads_we = 1'b1;
				end else begin
					links_we = 1'b1;
				end
			end
			S_REM_LINK: begin
				heads_wd = link_rd_q;
				links_wd = link_rd_q;
				if (prev_q == NULL_LINK) begin
					heads_we = 1'b1;
				end else begin
					links_we = 1'b1;
				end
			end
			S_REM_FREE: begin
				links_we = 1'b1;
				links_wa = cur_q[IW-1:0];
				links_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (heads_we) begin
			heads_mem[heads_wa] <= heads_wd;
		end
		head_rd_q <= heads_mem[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (links_we) begin
			links_mem[links_wa] <= links_wd;
		end
		link_rd_q <= links_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (keys_we) begin
			keys_mem[free_q[IW-1:0]] <= key_q;
		end
		key_rd_q <= keys_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			sweep_q   <= '0;
			free_q    <= '0;
			count_q   <= '0;
			hash_go_q <= 1'b0;
		end else begin
			hash_go_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_q == SW'(MAXD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						hash_go_q <= 1'b1;
						state_q   <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_LOAD;
				S_LOAD: state_q <= S_WALK;
				S_WALK: begin
					if (cur_q == NULL_LINK || steps_q == LW'(POOL_SIZE)) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= (key_rd_q == key_q) ? S_DECIDE : S_WALK;
				end
				S_DECIDE: begin
					if (func_q == FUNC_ADD) begin
						if (found_q || free_q == NULL_LINK) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_ALLOC;
						end
					end else if (func_q == FUNC_REMOVE && found_q) begin
						state_q <= S_REM_LINK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_ALLOC: begin
					free_q  <= link_rd_q;
					state_q <= S_ADD_LINK;
				end
				S_ADD_LINK: begin
					count_q <= count_q + LW'(1);
					state_q <= S_RESP;
				end
				S_REM_LINK: state_q <= S_REM_FREE;
				S_REM_FREE: begin
					free_q <= cur_q;
					if (count_q != '0) begin
						count_q <= count_q - LW'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// Datapath registers of the walk and the result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				key_q  <= req.key;
			end
			S_HASH: bucket_q <= hash_bucket;
			S_LOAD: begin
				cur_q   <= head_rd_q;
				prev_q  <= NULL_LINK;
				steps_q <= '0;
				found_q <= 1'b0;
			end
			S_CMP: begin
				if (key_rd_q == key_q) begin
					found_q <= 1'b1;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + LW'(1);
				end
			end
			S_DECIDE: begin
				new_q <= free_q;
				if (func_q == FUNC_ADD) begin
					if (found_q) begin
						status_q <= STAT_PRESENT;
					end else if (free_q == NULL_LINK) begin
						status_q <= STAT_POOL_FULL;
					end else begin
						status_q <= STAT_ADDED;
					end
				end else if (func_q == FUNC_REMOVE) begin
					status_q <= found_q ? STAT_REMOVED : STAT_NOT_PRESENT;
				end else begin
					status_q <= found_q ? STAT_PRESENT : STAT_NOT_PRESENT;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/chs_checker.sv @@
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the chained hash set, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             found,
	input wire chs_pkg::status_t status
);
	import chs_pkg::*;

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	// One request at a time: no request transfer while a result waits.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid)
		else $error("request taken while a result is pending");

	// No result is offered in the cycle after a request transfer.
	a_no_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid)
		else $error("result offered one cycle after request transfer");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (found && (status == STAT_PRESENT || status == STAT_REMOVED)) ||
			(!found && (status == STAT_ADDED || status == STAT_NOT_PRESENT ||
			status == STAT_POOL_FULL)))
		else $error("found flag disagrees with status");
endmodule

bind chained_hash_set_core chs_checker u_chs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.found     (rsp.found),
	.status    (rsp.status)
);
`default_nettype wire

@@ tb/chained_hash_set_core_tb.sv @@
// ----------------------------------------------------------------------------
// chained_hash_set_core_tb
// Drives add, query, remove and spare requests through the request channel and
// checks every result against a behavioral chained hash set kept here.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_set_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chs_pkg::*;

	localparam int NB       = 256;
	localparam int PS       = 256;
	localparam int NIL      = PS;
	localparam int CYC_MAX  = 5000000;

	typedef struct packed {
		logic    found;
		status_t status;
		count_t  member_count;
	} outcome_t;

	typedef struct {
		func_t    func;
		key_t     key;
		logic     typed;
		outcome_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	chs_req_if req ();
	chs_rsp_if rsp ();

	chained_hash_set_core #(.NUM_BUCKETS(NB), .POOL_SIZE(PS)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the hash table.
	int   heads [NB];
	key_t nkeys [PS];
	int   links [PS];
	int   free_node;
	int   members;

	outcome_t pending_results [$];
	int       errors = 0;
	int       cycles = 0;
	logic     stim_done = 1'b0;

	task automatic report(input string what, input outcome_t got, input outcome_t want);
		$display("mismatch %s: got found=%0d status=%0d count=%0d, want %0d %0d %0d",
			what, got.found, got.status, got.member_count,
			want.found, want.status, want.member_count);
		errors++;
	endtask

	task automatic table_clear();
		for (int i = 0; i < NB; i++) heads[i] = NIL;
		for (int i = 0; i < PS; i++) begin
			links[i] = i + 1;
			nkeys[i] = '0;
		end
		free_node = 0;
		members = 0;
	endtask

	function automatic int bucket_of(key_t k);
		logic [31:0] mag;
		mag = k[31] ? (32'd0 - k) : k;
		return int'(mag % NB);
	endfunction

	function automatic outcome_t apply_request(func_t f, key_t k);
		int b, cur, pv, hit, steps, n;
		outcome_t o;
		b = bucket_of(k);
		cur = heads[b];
		pv = NIL;
		hit = NIL;
		steps = 0;
		while (cur < PS && steps < PS) begin
			if (nkeys[cur] == k) begin
				hit = cur;
				break;
			end
			pv = cur;
			cur = links[cur];
			steps++;
		end
		o.found = (hit < PS);
		if (f == FUNC_ADD) begin
			if (o.found) o.status = STAT_PRESENT;
			else if (free_node >= PS) o.status = STAT_POOL_FULL;
			else begin
				n = free_node;
				free_node = links[n];
				nkeys[n] = k;
				links[n] = NIL;
				if (pv < PS) links[pv] = n;
				else heads[b] = n;
				members++;
				o.status = STAT_ADDED;
			end
		end else if (f == FUNC_REMOVE) begin
			if (o.found) begin
				if (pv < PS) links[pv] = links[hit];
				else heads[b] = links[hit];
				links[hit] = free_node;
				free_node = hit;
				if (members > 0) members--;
				o.status = STAT_REMOVED;
			end else o.status = STAT_NOT_PRESENT;
		end else begin
			o.status = o.found ? STAT_PRESENT : STAT_NOT_PRESENT;
		end
		o.member_count = count_t'(members);
		return o;
	endfunction

	function automatic row_t mk(func_t f, key_t k, logic t = 1'b0,
			logic fd = 1'b0, status_t s = STAT_ADDED, int c = 0);
		row_t r;
		r.func = f;
		r.key = k;
		r.typed = t;
		r.want.found = fd;
		r.want.status = s;
		r.want.member_count = count_t'(c);
		return r;
	endfunction

	// Directed rows checked against typed values where obvious.
	row_t directed [$];
	key_t recent [$];

	initial begin
		directed.push_back(mk(FUNC_QUERY, 32'h8000_0000, 1, 0, STAT_NOT_PRESENT, 0));
		directed.push_back(mk(FUNC_REMOVE, 32'h7fff_ffff, 1, 0, STAT_NOT_PRESENT, 0));
		directed.push_back(mk(FUNC_ADD, 32'h8000_0000, 1, 0, STAT_ADDED, 1));
		directed.push_back(mk(FUNC_ADD, 32'h8000_0000, 1, 1, STAT_PRESENT, 1));
		directed.push_back(mk(FUNC_ADD, 32'h7fff_ffff, 1, 0, STAT_ADDED, 2));
		directed.push_back(mk(FUNC_ADD, 32'h0000_0000, 1, 0, STAT_ADDED, 3));
		directed.push_back(mk(FUNC_ADD, 32'hffff_ffff, 1, 0, STAT_ADDED, 4));
		directed.push_back(mk(FUNC_ADD, 32'h0000_0001));
		// Same bucket as zero and 0x80000000: builds a chain of four.
		directed.push_back(mk(FUNC_ADD, 32'h0000_0100));
		directed.push_back(mk(FUNC_ADD, 32'hffff_ff00));
		directed.push_back(mk(FUNC_SPARE, 32'h0000_0100));
		directed.push_back(mk(FUNC_REMOVE, 32'h0000_0100));
		directed.push_back(mk(FUNC_QUERY, 32'hffff_ff00));
		directed.push_back(mk(FUNC_REMOVE, 32'h0000_0000));
		directed.push_back(mk(FUNC_QUERY, 32'h0000_0100));
		directed.push_back(mk(FUNC_SPARE, 32'h1234_5678));
		directed.push_back(mk(FUNC_REMOVE, 32'hffff_ff00));
		directed.push_back(mk(FUNC_REMOVE, 32'h8000_0000));
		directed.push_back(mk(FUNC_ADD, 32'h5555_aaaa));
		directed.push_back(mk(FUNC_QUERY, 32'haaaa_5555));
	end

	task automatic send(input func_t f, input key_t k);
		req.valid <= 1'b1;
		req.func  <= f;
		req.key   <= k;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(apply_request(f, k));
	endtask

	task automatic gap();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic key_t pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (recent.size() > 0 && sel < 5) return recent[$urandom_range(0, recent.size() - 1)];
		if (sel < 7) return key_t'({$urandom_range(0, 3), $urandom_range(0, 255)}) * 256
			+ key_t'($urandom_range(0, 7));
		if (sel == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		return $urandom;
	endfunction

	task automatic send_random(input int add_weight);
		func_t f;
		key_t k;
		int r;
		r = $urandom_range(0, 99);
		f = (r < add_weight) ? FUNC_ADD : (r < 75) ? FUNC_REMOVE
			: (r < 93) ? FUNC_QUERY : FUNC_SPARE;
		k = pick_key();
		if (f == FUNC_ADD) begin
			recent.push_back(k);
			if (recent.size() > 400) void'(recent.pop_front());
		end
		send(f, k);
	endtask

	initial begin
		int burst;
		req.valid = 1'b0;
		req.func = FUNC_QUERY;
		req.key = '0;
		table_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send(directed[i].func, directed[i].key);
			if (directed[i].typed && pending_results[$] != directed[i].want)
				report("typed row", pending_results[$], directed[i].want);
			if ($urandom_range(0, 2) == 0) gap();
		end
		// Mixed traffic, then a fill phase to exhaust the pool, then drain.
		for (int n = 0; n < 1450; ) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst && n < 1450; j++, n++)
				send_random(n < 600 ? 45 : (n < 1000 ? 90 : 10));
			if ($urandom_range(0, 3) != 0) gap();
		end
		req.valid <= 1'b0;
		stim_done <= 1'b1;
	end

	// Receiver is always ready for part of each period and else stalls on an LFSR pattern.
	logic [7:0] stall_lfsr = 8'h5a;
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
			^ stall_lfsr[3]};
		rsp.ready <= (cycles % 512 < 128) ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
	end

	always @(posedge clk) begin
		outcome_t got, want;
		cycles <= cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.found = rsp.found;
			got.status = rsp.status;
			got.member_count = rsp.member_count;
			if (pending_results.size() == 0) begin
				report("unexpected transfer", got, got);
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found) report("found", got, want);
				if (got.status !== want.status) report("status", got, want);
				if (got.member_count !== want.member_count)
					report("member_count", got, want);
			end
		end
	end

	initial begin
		wait (stim_done === 1'b1);
		while (pending_results.size() != 0 && cycles < CYC_MAX) @(posedge clk);
		if (cycles < CYC_MAX) repeat (1200) @(posedge clk);
		if (cycles >= CYC_MAX) begin
			$display("[FAIL] regression broken");
		end else if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		wait (cycles >= CYC_MAX);
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
